>>> rtl/u8u16_pkg.sv
// shared types and constants for the utf-8 to utf-16 transcoder
package u8u16_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned UNIT_W    = 16;
	localparam int unsigned CP_W      = 21;
	localparam int unsigned PEND_W    = 2;
	localparam int unsigned CNT_W     = 2;
	localparam int unsigned BUF_DEPTH = 2;

	localparam logic [CP_W-1:0]   CP_OFFSET  = 21'h10000;
	localparam logic [UNIT_W-1:0] HI_SURR    = 16'hd800;
	localparam logic [UNIT_W-1:0] LO_SURR    = 16'hdc00;
	localparam logic [UNIT_W-1:0] BAD_UNIT   = 16'h0000;
	localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
	localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
	localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
	localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic              last;
	} entry_t;

	typedef struct packed {
		logic [CNT_W-1:0]  n;
		entry_t            ent0;
		entry_t            ent1;
		logic [CP_W-1:0]   cp_next;
		logic [PEND_W-1:0] pend_next;
	} decode_t;

endpackage

>>> rtl/u8u16_decode.sv
// combinational decode of one utf-8 byte against the open sequence state
module u8u16_decode (
	input  logic [u8u16_pkg::BYTE_W-1:0] in_byte,
	input  logic                         stream_end,
	input  logic [u8u16_pkg::CP_W-1:0]   cp,
	input  logic [u8u16_pkg::PEND_W-1:0] pend,
	output u8u16_pkg::decode_t           dec
);

	logic [u8u16_pkg::CNT_W-1:0]  n;
	logic [u8u16_pkg::UNIT_W-1:0] u0;
	logic [u8u16_pkg::UNIT_W-1:0] u1;
	logic [u8u16_pkg::CP_W-1:0]   cp_n;
	logic [u8u16_pkg::PEND_W-1:0] pend_n;
	logic [u8u16_pkg::CP_W-1:0]   cp_acc;
	logic [u8u16_pkg::CP_W-1:0]   v;
	logic [u8u16_pkg::PEND_W-1:0] pend_dec;
	logic                         is_cont;
	logic                         do_lead;
	logic                         lead_emit;
	logic [u8u16_pkg::UNIT_W-1:0] lead_unit;
	logic [u8u16_pkg::CP_W-1:0]   lead_cp;
	logic [u8u16_pkg::PEND_W-1:0] lead_pend;

	assign is_cont  = (in_byte[7:6] == 2'b10);
	assign cp_acc   = {cp[u8u16_pkg::CP_W-7:0], in_byte[5:0]};
	assign pend_dec = pend - u8u16_pkg::PEND_ONE;
	assign v        = cp_acc - u8u16_pkg::CP_OFFSET;

	// lead byte classification
	always_comb begin
		lead_emit = 1'b0;
		lead_unit = u8u16_pkg::BAD_UNIT;
		lead_cp   = '0;
		lead_pend = u8u16_pkg::PEND_NONE;
		if (in_byte[7:5] == 3'b110) begin
			lead_cp   = {16'd0, in_byte[4:0]};
			lead_pend = u8u16_pkg::PEND_ONE;
		end else if (in_byte[7:4] == 4'b1110) begin
			lead_cp   = {17'd0, in_byte[3:0]};
			lead_pend = u8u16_pkg::PEND_TWO;
		end else if (in_byte[7:3] == 5'b11110) begin
			lead_cp   = {18'd0, in_byte[2:0]};
			lead_pend = u8u16_pkg::PEND_THREE;
		end else if (in_byte[7]) begin
			lead_emit = 1'b1;
		end else begin
			lead_emit = 1'b1;
			lead_unit = {8'd0, in_byte};
		end
	end

	always_comb begin
		n       = 2'd0;
		u0      = u8u16_pkg::BAD_UNIT;
		u1      = u8u16_pkg::BAD_UNIT;
		cp_n    = cp;
		pend_n  = pend;
		do_lead = 1'b0;
		if (pend != u8u16_pkg::PEND_NONE) begin
			if (is_cont) begin
				cp_n   = cp_acc;
				pend_n = pend_dec;
				if (pend_dec == u8u16_pkg::PEND_NONE) begin
					cp_n = '0;
					if (cp_acc[u8u16_pkg::CP_W-1:16] != '0) begin
						n  = 2'd2;
						u0 = u8u16_pkg::HI_SURR | {6'd0, v[19:10]};
						u1 = u8u16_pkg::LO_SURR | {6'd0, v[9:0]};
					end else begin
						n  = 2'd1;
						u0 = cp_acc[15:0];
					end
				end
			end else begin
				// broken sequence, byte restarts as a lead
				n       = 2'd1;
				u0      = u8u16_pkg::BAD_UNIT;
				do_lead = 1'b1;
			end
		end else begin
			do_lead = 1'b1;
		end
		if (do_lead) begin
			cp_n   = lead_cp;
			pend_n = lead_pend;
			if (lead_emit) begin
				if (n == 2'd0) begin
					u0 = lead_unit;
				end else begin
					u1 = lead_unit;
				end
				n = n + 2'd1;
			end
		end
		if (stream_end) begin
			if (pend_n != u8u16_pkg::PEND_NONE) begin
				if (n == 2'd0) begin
					u0 = u8u16_pkg::BAD_UNIT;
				end else begin
					u1 = u8u16_pkg::BAD_UNIT;
				end
				n = n + 2'd1;
			end
			cp_n   = '0;
			pend_n = u8u16_pkg::PEND_NONE;
		end
	end

	assign dec.n         = n;
	assign dec.ent0.unit = u0;
	assign dec.ent0.last = (n == 2'd1);
	assign dec.ent1.unit = u1;
	assign dec.ent1.last = 1'b1;
	assign dec.cp_next   = cp_n;
	assign dec.pend_next = pend_n;

endmodule

>>> rtl/utf8_to_utf16_transcoder_core.sv
// top level of the utf-8 to utf-16 transcoder
//
// s_* channel: one utf-8 byte per transaction in s_tdata, s_tlast marks the
// final byte of a string. m_* channel: one utf-16 unit per transaction in
// m_tdata, m_tlast set on the last unit caused by an input byte.
// a byte is held in an input register and decoded in the next cycle. its
// zero, one or two units are then written into a two-entry output buffer,
// from which the first unit can then be taken.
// throughput is one byte per cycle while m_tready stays high. a byte that
// yields two units (surrogate pair or malformed sequence) holds up the input,
// because the buffer drains one unit per cycle.
// a unit leaving the buffer frees its entry in the same cycle, so s_tready
// also follows m_tready. when the receiver stalls, the buffer fills and the
// input register holds its byte until room frees up.
// reset clears the open sequence, the input register and the output buffer.
// malformed input yields the unit 0x0000; a sequence still open at the byte
// flagged s_tlast yields one more 0x0000 and the state returns to idle.
module utf8_to_utf16_transcoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] unit_value
	output logic        m_tlast
);

	logic                         valid_s1;
	logic [u8u16_pkg::BYTE_W-1:0] byte_s1;
	logic                         last_s1;
	logic [u8u16_pkg::CP_W-1:0]   cp_q;
	logic [u8u16_pkg::PEND_W-1:0] pend_q;
	u8u16_pkg::entry_t            ent_q [u8u16_pkg::BUF_DEPTH];
	u8u16_pkg::entry_t            ent_n [u8u16_pkg::BUF_DEPTH];
	logic [u8u16_pkg::CNT_W-1:0]  cnt_q;
	logic [u8u16_pkg::CNT_W-1:0]  cnt_n;
	logic [u8u16_pkg::CNT_W-1:0]  cnt_pop;
	logic [u8u16_pkg::CNT_W-1:0]  space;
	u8u16_pkg::decode_t           dec;
	logic                         advance;
	logic                         take;
	logic                         pop;

	u8u16_decode u_decode (
		.in_byte    (byte_s1),
		.stream_end (last_s1),
		.cp         (cp_q),
		.pend       (pend_q),
		.dec        (dec)
	);

	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign cnt_pop  = pop ? (cnt_q - 2'd1) : cnt_q;
	assign space    = u8u16_pkg::CNT_W'(u8u16_pkg::BUF_DEPTH) - cnt_pop;
	assign advance  = valid_s1 && (dec.n <= space);
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;
	assign m_tdata  = ent_q[0].unit;
	assign m_tlast  = ent_q[0].last;

	always_comb begin
		ent_n = ent_q;
		if (pop) begin
			ent_n[0] = ent_q[1];
		end
		cnt_n = cnt_pop;
		if (advance) begin
			if (dec.n != 2'd0) begin
				if (cnt_pop == 2'd0) begin
					ent_n[0] = dec.ent0;
				end else begin
					ent_n[1] = dec.ent0;
				end
			end
			if (dec.n == 2'd2) begin
				ent_n[1] = dec.ent1;
			end
			cnt_n = cnt_pop + dec.n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cp_q     <= '0;
			pend_q   <= u8u16_pkg::PEND_NONE;
			cnt_q    <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				cp_q   <= dec.cp_next;
				pend_q <= dec.pend_next;
			end
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		ent_q <= ent_n;
	end

endmodule

>>> rtl/u8u16_checker.sv
// port-level checker for the transcoder and its bind to the top level
module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// stalled input transaction holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
		else $error("input transaction changed while stalled");

	// stalled transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	// a unit that is not the last of its byte is a high surrogate or malformed
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[15:10] == 6'b110110) || (m_tdata == 16'h0000))
		else $error("unexpected first unit of a pair");

	// low surrogate always closes its byte
	a_lo_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[15:10] == 6'b110111) |-> m_tlast)
		else $error("low surrogate not marked last");

	// second unit of a pair is ready right after the first
	a_pair_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("second unit of a pair missing");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
